@@ rtl/order_event_normalizer_macros.svh @@
// ----------------------------------------------------------------------------
// Order event normalizer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ORDER_EVENT_NORMALIZER_MACROS_SVH
`define ORDER_EVENT_NORMALIZER_MACROS_SVH

// Same-cycle implication
`define OEN_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("order_event_normalizer: same-cycle check failed");

// Next-cycle implication
`define OEN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("order_event_normalizer: next-cycle check failed");

`endif

@@ rtl/oen_pkg.sv @@
// ----------------------------------------------------------------------------
// oen_pkg
// Types, codes and sizes shared by the order event normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package oen_pkg;

   // Event commands
   localparam logic [3:0] CMD_ADD     = 4'd0;
   localparam logic [3:0] CMD_MODIFY  = 4'd1;
   localparam logic [3:0] CMD_DELETE  = 4'd2;
   localparam logic [3:0] CMD_EXECUTE = 4'd3;
   localparam logic [3:0] CMD_REPLACE = 4'd4;

   // Output message kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_MODIFY = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_TRADE  = 2'd3;

   localparam logic [7:0]  SELL_CHAR   = 8'h53;
   localparam logic [7:0]  ABSENT_CHAR = 8'h00;
   localparam logic [63:0] SEQ_RESET   = 64'd1;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified event; a replace carries both of its messages
   typedef struct packed {
      logic        is_replace;
      logic [1:0]  kind;
      logic [63:0] event_time;
      logic [31:0] symbol;
      logic [63:0] order_ref;
      logic [63:0] new_order_ref;
      logic [62:0] price;
      logic [31:0] quantity;
      logic        is_sell;
   } job_type;

   // One outgoing message
   typedef struct packed {
      logic [1:0]  message_kind;
      logic [63:0] sequence_number;
      logic [63:0] out_time;
      logic [31:0] out_symbol;
      logic [63:0] out_order;
      logic [62:0] out_price;
      logic [31:0] out_quantity;
      logic        is_sell;
      logic        last_of_event;
   } msg_type;

endpackage

`default_nettype wire

@@ rtl/oen_front.sv @@
// ----------------------------------------------------------------------------
// oen_front
// Checks an incoming event against the rules of its kind and builds the job
// that the back end turns into messages. Dropped events produce no job.
// ----------------------------------------------------------------------------
`default_nettype none

module oen_front (
   input  wire logic               req_push,
   input  wire logic [3:0]         req_command,
   input  wire logic [63:0]        req_event_time,
   input  wire logic [31:0]        req_symbol,
   input  wire logic [63:0]        req_order_ref,
   input  wire logic [63:0]        req_new_order_ref,
   input  wire logic signed [63:0] req_price_in_ticks,
   input  wire logic [31:0]        req_quantity,
   input  wire logic [7:0]         req_side_char,
   input  wire logic               q_full,
   output logic                    job_valid,
   output oen_pkg::job_type        job
);

   logic price_ok;
   logic qty_ok;
   logic side_ok;
   logic sym_ok;
   logic emit;

   assign price_ok = ~req_price_in_ticks[63];
   assign qty_ok   = (req_quantity != 32'd0);
   assign side_ok  = (req_side_char != oen_pkg::ABSENT_CHAR);
   assign sym_ok   = (req_symbol != 32'd0);

   // Classify the event
   always_comb begin
      job.is_replace    = 1'b0;
      job.kind          = oen_pkg::KIND_ADD;
      job.event_time    = req_event_time;
      job.symbol        = req_symbol;
      job.order_ref     = req_order_ref;
      job.new_order_ref = req_new_order_ref;
      job.price         = price_ok ? req_price_in_ticks[62:0] : 63'd0;
      job.quantity      = req_quantity;
      job.is_sell       = (req_side_char == oen_pkg::SELL_CHAR);
      emit              = 1'b0;
      unique case (req_command)
         oen_pkg::CMD_ADD: begin
            job.kind = oen_pkg::KIND_ADD;
            emit     = price_ok && qty_ok && side_ok;
         end
         oen_pkg::CMD_MODIFY: begin
            job.kind = oen_pkg::KIND_MODIFY;
            emit     = price_ok && side_ok;
         end
         oen_pkg::CMD_DELETE: begin
            job.kind     = oen_pkg::KIND_DELETE;
            job.price    = 63'd0;
            job.quantity = 32'd0;
            emit         = 1'b1;
         end
         oen_pkg::CMD_EXECUTE: begin
            job.kind = oen_pkg::KIND_TRADE;
            emit     = qty_ok;
         end
         oen_pkg::CMD_REPLACE: begin
            // delete half is built by the back end
            job.is_replace = 1'b1;
            job.kind       = oen_pkg::KIND_ADD;
            emit           = price_ok && qty_ok && side_ok &&
                             (req_new_order_ref != 64'd0);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Only accepted events that pass go into the queue
   assign job_valid = req_push && !q_full && sym_ok && emit;

endmodule

`default_nettype wire

@@ rtl/oen_queue.sv @@
// ----------------------------------------------------------------------------
// oen_queue
// Small register queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module oen_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire oen_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output oen_pkg::job_type      head
);

   oen_pkg::job_type entry_ff [oen_pkg::QUEUE_DEPTH];

   logic [oen_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [oen_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [oen_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full    = (count_ff == oen_pkg::QUEUE_CNT_W'(oen_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + oen_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + oen_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + oen_pkg::QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - oen_pkg::QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/oen_back.sv @@
// ----------------------------------------------------------------------------
// oen_back
// Expands queued jobs into messages, stamps each with the sequence counter
// and holds the current message in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module oen_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [63:0]      csr_write_data,
   input  wire oen_pkg::job_type head,
   input  wire logic             q_empty,
   output logic                  q_pop,
   input  wire logic             rsp_pop,
   output logic                  rsp_empty,
   output oen_pkg::msg_type      msg
);

   logic             out_valid_ff, out_valid_in;
   logic             phase_ff, phase_in;
   logic [63:0]      seq_ff, seq_in;
   oen_pkg::msg_type msg_ff, msg_in;
   logic             load;
   logic             first_half;

   // Load a new message when the output register is free or being taken
   assign load       = !q_empty && (!out_valid_ff || rsp_pop);
   assign first_half = head.is_replace && !phase_ff;
   assign q_pop      = load && !first_half;
   assign rsp_empty  = !out_valid_ff;
   assign msg        = msg_ff;

   // Build the next message; first half of a replace is a delete
   always_comb begin
      msg_in.message_kind    = first_half ? oen_pkg::KIND_DELETE : head.kind;
      msg_in.sequence_number = seq_ff;
      msg_in.out_time        = head.event_time;
      msg_in.out_symbol      = head.symbol;
      msg_in.out_order       = (head.is_replace && phase_ff) ? head.new_order_ref
                                                             : head.order_ref;
      msg_in.out_price       = first_half ? 63'd0 : head.price;
      msg_in.out_quantity    = first_half ? 32'd0 : head.quantity;
      msg_in.is_sell         = head.is_sell;
      msg_in.last_of_event   = !first_half;
   end

   // Control next state
   always_comb begin
      phase_in     = load ? first_half : phase_ff;
      out_valid_in = load ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
      priority if (csr_write_enable) begin
         seq_in = csr_write_data;
      end else if (load) begin
         seq_in = seq_ff + 64'd1;
      end else begin
         seq_in = seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         seq_ff       <= oen_pkg::SEQ_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         msg_ff <= msg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/order_event_normalizer.sv @@
// Path: an accepted event is written into the job queue, then loaded into the output register that drives rsp_.
// Intake: one event per cycle while the job queue is not full; a replace yields a delete then an add message.
// The message rate is set by the single output register, one message per cycle while the consumer pops.
// A 4-entry job queue lets intake run ahead of a stalled consumer.
// Reset: queue and output empty, sequence counter loaded with 1.
// ----------------------------------------------------------------------------
// order_event_normalizer
// Turns decoded order events into sequenced book messages: front end checks
// and classifies, a job queue decouples, back end expands and stamps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "order_event_normalizer_macros.svh"

module order_event_normalizer (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write_enable,
   input  wire logic [63:0]        csr_write_data,
   // event input
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [3:0]         req_command,
   input  wire logic [63:0]        req_event_time,
   input  wire logic [31:0]        req_symbol,
   input  wire logic [63:0]        req_order_ref,
   input  wire logic [63:0]        req_new_order_ref,
   input  wire logic signed [63:0] req_price_in_ticks,
   input  wire logic [31:0]        req_quantity,
   input  wire logic [7:0]         req_side_char,
   // message output
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [1:0]              rsp_message_kind,
   output logic [63:0]             rsp_sequence_number,
   output logic [63:0]             rsp_out_time,
   output logic [31:0]             rsp_out_symbol,
   output logic [63:0]             rsp_out_order,
   output logic [62:0]             rsp_out_price,
   output logic [31:0]             rsp_out_quantity,
   output logic                    rsp_is_sell,
   output logic                    rsp_last_of_event
);

   logic             job_valid;
   oen_pkg::job_type job;
   oen_pkg::job_type head;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;
   oen_pkg::msg_type msg;

   assign req_full = q_full;

   oen_front u_front (
      .req_push           (req_push),
      .req_command        (req_command),
      .req_event_time     (req_event_time),
      .req_symbol         (req_symbol),
      .req_order_ref      (req_order_ref),
      .req_new_order_ref  (req_new_order_ref),
      .req_price_in_ticks (req_price_in_ticks),
      .req_quantity       (req_quantity),
      .req_side_char      (req_side_char),
      .q_full             (q_full),
      .job_valid          (job_valid),
      .job                (job)
   );

   oen_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   oen_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .msg              (msg)
   );

   // Unpack the output message
   assign rsp_message_kind    = msg.message_kind;
   assign rsp_sequence_number = msg.sequence_number;
   assign rsp_out_time        = msg.out_time;
   assign rsp_out_symbol      = msg.out_symbol;
   assign rsp_out_order       = msg.out_order;
   assign rsp_out_price       = msg.out_price;
   assign rsp_out_quantity    = msg.out_quantity;
   assign rsp_is_sell         = msg.is_sell;
   assign rsp_last_of_event   = msg.last_of_event;

   // Only the delete half of a replace is not last
   `OEN_ASSERT_SAME(a_not_last_is_delete, clock, reset, !rsp_empty && !rsp_last_of_event, rsp_message_kind == oen_pkg::KIND_DELETE)

   // Deletes carry no price and no quantity
   `OEN_ASSERT_SAME(a_delete_zeroed, clock, reset, !rsp_empty && rsp_message_kind == oen_pkg::KIND_DELETE, rsp_out_price == 63'd0 && rsp_out_quantity == 32'd0)

   // The add of a replace follows its delete with no gap
   `OEN_ASSERT_NEXT(a_replace_back_to_back, clock, reset, rsp_pop && !rsp_empty && !rsp_last_of_event, !rsp_empty && rsp_last_of_event)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: order event normalizer testbench
// Drives decoded order events into the block and checks every book message
// against a local predictor of the normalizing rules and sequence counter.
// Directed rule cases come first, then counter wrap and reload, then long
// random traffic with stalls on both sides in all but one phase, and reloads between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Commands the block ignores
   localparam logic [3:0] CMD_TRADE_REPORT = 4'd5;
   localparam logic [3:0] CMD_IMBALANCE    = 4'd6;
   localparam logic [3:0] CMD_STATUS       = 4'd7;
   localparam logic [3:0] CMD_SUMMARY      = 4'd8;
   localparam logic [3:0] CMD_UNKNOWN      = 4'd9;
   localparam logic [3:0] CMD_MAX          = 4'd15;

   localparam logic [7:0]         BUY_CHAR  = 8'h42;
   localparam logic signed [63:0] PRICE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PRICE_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [31:0]        QTY_MAX   = 32'hFFFF_FFFF;
   localparam logic [63:0]        ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int DRAIN_CYCLES  = 6;
   localparam int WATCHDOG_MAX  = 1000;
   localparam int PHASE_ITEMS   = 300;

   typedef struct {
      logic [3:0]         command;
      logic [63:0]        event_time;
      logic [31:0]        symbol;
      logic [63:0]        order_ref;
      logic [63:0]        new_order_ref;
      logic signed [63:0] price;
      logic [31:0]        quantity;
      logic [7:0]         side_char;
   } order_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [63:0]        csr_write_data = '0;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [3:0]         req_command = '0;
   logic [63:0]        req_event_time = '0;
   logic [31:0]        req_symbol = '0;
   logic [63:0]        req_order_ref = '0;
   logic [63:0]        req_new_order_ref = '0;
   logic signed [63:0] req_price_in_ticks = '0;
   logic [31:0]        req_quantity = '0;
   logic [7:0]         req_side_char = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [1:0]         rsp_message_kind;
   logic [63:0]        rsp_sequence_number;
   logic [63:0]        rsp_out_time;
   logic [31:0]        rsp_out_symbol;
   logic [63:0]        rsp_out_order;
   logic [62:0]        rsp_out_price;
   logic [31:0]        rsp_out_quantity;
   logic               rsp_is_sell;
   logic               rsp_last_of_event;

   // Predictor state and pending book messages
   logic [63:0]      next_seq_model = 64'd1;
   oen_pkg::msg_type book_msgs_due[$];
   int               error_count = 0;
   int               idle_cycles = 0;
   int               pop_wait = 0;
   bit               traffic_stall = 1'b1;

   order_event_normalizer u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_command         (req_command),
      .req_event_time      (req_event_time),
      .req_symbol          (req_symbol),
      .req_order_ref       (req_order_ref),
      .req_new_order_ref   (req_new_order_ref),
      .req_price_in_ticks  (req_price_in_ticks),
      .req_quantity        (req_quantity),
      .req_side_char       (req_side_char),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_message_kind    (rsp_message_kind),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_out_time        (rsp_out_time),
      .rsp_out_symbol      (rsp_out_symbol),
      .rsp_out_order       (rsp_out_order),
      .rsp_out_price       (rsp_out_price),
      .rsp_out_quantity    (rsp_out_quantity),
      .rsp_is_sell         (rsp_is_sell),
      .rsp_last_of_event   (rsp_last_of_event)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly back to back, some short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic order_event_type build_event(input logic [3:0] command,
                                                   input logic [63:0] event_time,
                                                   input logic [31:0] symbol,
                                                   input logic [63:0] order_ref,
                                                   input logic [63:0] new_order_ref,
                                                   input logic signed [63:0] price,
                                                   input logic [31:0] quantity,
                                                   input logic [7:0] side_char);
      order_event_type ev;
      ev.command       = command;
      ev.event_time    = event_time;
      ev.symbol        = symbol;
      ev.order_ref     = order_ref;
      ev.new_order_ref = new_order_ref;
      ev.price         = price;
      ev.quantity      = quantity;
      ev.side_char     = side_char;
      return ev;
   endfunction

   // Mostly well-formed book events; each check fails now and then
   function automatic order_event_type random_event();
      order_event_type ev;
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) ev.command = 4'($urandom_range(oen_pkg::CMD_ADD, oen_pkg::CMD_REPLACE));
      else        ev.command = 4'($urandom_range(CMD_TRADE_REPORT, CMD_MAX));
      ev.event_time = rand64();
      ev.order_ref  = rand64();

      r = $urandom_range(0, 99);
      if (r < 3)       ev.symbol = '0;
      else if (r < 10) ev.symbol = 32'hFFFF_FFFF;
      else if (r < 50) ev.symbol = $urandom_range(1, 500);
      else             ev.symbol = $urandom | 32'd1;

      r = $urandom_range(0, 99);
      if (r < 4)       ev.new_order_ref = '0;
      else if (r < 10) ev.new_order_ref = ALL_ONES;
      else             ev.new_order_ref = rand64() | 64'd1;

      r = $urandom_range(0, 99);
      if (r < 5)       ev.price = PRICE_MIN;
      else if (r < 9)  ev.price = {1'b1, 63'(rand64())};
      else if (r < 14) ev.price = '0;
      else if (r < 19) ev.price = PRICE_MAX;
      else if (r < 60) ev.price = 64'($urandom_range(1, 100000));
      else             ev.price = {1'b0, 63'(rand64())};

      r = $urandom_range(0, 99);
      if (r < 6)       ev.quantity = '0;
      else if (r < 12) ev.quantity = QTY_MAX;
      else if (r < 60) ev.quantity = $urandom_range(1, 10000);
      else             ev.quantity = $urandom | 32'd1;

      r = $urandom_range(0, 99);
      if (r < 6)       ev.side_char = oen_pkg::ABSENT_CHAR;
      else if (r < 45) ev.side_char = oen_pkg::SELL_CHAR;
      else if (r < 75) ev.side_char = BUY_CHAR;
      else             ev.side_char = 8'($urandom_range(1, 255));
      return ev;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void stamp_message(input oen_pkg::msg_type m);
      m.sequence_number = next_seq_model;
      book_msgs_due = {book_msgs_due, m};
      next_seq_model = next_seq_model + 64'd1;
   endfunction

   function automatic void normalize_event(input order_event_type ev);
      oen_pkg::msg_type m;
      logic             price_ok;
      logic             has_side;
      price_ok          = ~ev.price[63];
      has_side          = (ev.side_char != oen_pkg::ABSENT_CHAR);
      m.message_kind    = oen_pkg::KIND_ADD;
      m.sequence_number = '0;
      m.out_time        = ev.event_time;
      m.out_symbol      = ev.symbol;
      m.out_order       = ev.order_ref;
      m.out_price       = price_ok ? ev.price[62:0] : '0;
      m.out_quantity    = ev.quantity;
      m.is_sell         = (ev.side_char == oen_pkg::SELL_CHAR);
      m.last_of_event   = 1'b1;
      if (ev.symbol == '0) return;
      case (ev.command)
         oen_pkg::CMD_ADD: begin
            if (price_ok && ev.quantity != '0 && has_side) stamp_message(m);
         end
         oen_pkg::CMD_MODIFY: begin
            m.message_kind = oen_pkg::KIND_MODIFY;
            if (price_ok && has_side) stamp_message(m);
         end
         oen_pkg::CMD_DELETE: begin
            m.message_kind = oen_pkg::KIND_DELETE;
            m.out_price    = '0;
            m.out_quantity = '0;
            stamp_message(m);
         end
         oen_pkg::CMD_EXECUTE: begin
            m.message_kind = oen_pkg::KIND_TRADE;
            if (ev.quantity != '0) stamp_message(m);
         end
         oen_pkg::CMD_REPLACE: begin
            if (price_ok && ev.quantity != '0 && has_side && ev.new_order_ref != '0) begin
               // delete of the old order, then add under the new id
               stamp_message('{message_kind: oen_pkg::KIND_DELETE, sequence_number: '0,
                               out_time: ev.event_time, out_symbol: ev.symbol,
                               out_order: ev.order_ref, out_price: '0,
                               out_quantity: '0, is_sell: m.is_sell,
                               last_of_event: 1'b0});
               m.out_order = ev.new_order_ref;
               stamp_message(m);
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------
   task automatic send_event(input order_event_type ev);
      int gap;
      gap = traffic_stall ? idle_length() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command        <= ev.command;
      req_event_time     <= ev.event_time;
      req_symbol         <= ev.symbol;
      req_order_ref      <= ev.order_ref;
      req_new_order_ref  <= ev.new_order_ref;
      req_price_in_ticks <= ev.price;
      req_quantity       <= ev.quantity;
      req_side_char      <= ev.side_char;
      req_push           <= 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      normalize_event(ev);
   endtask

   // Sender holds off until every predicted message has been popped
   task automatic wait_for_results();
      req_push <= 1'b0;
      do @(posedge clock); while (book_msgs_due.size() != 0);
   endtask

   // Also covers dropped events still in flight
   task automatic wait_for_idle();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_first_sequence(input logic [63:0] value);
      wait_for_idle();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      next_seq_model = value;
   endtask

   // ---------------------------------------------------------------------
   // Output side: random pop stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
      end else if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait--;
      end else begin
         rsp_pop <= 1'b1;
         if (traffic_stall) pop_wait = idle_length();
      end
   end

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_book_message();
      oen_pkg::msg_type want;
      if (book_msgs_due.size() == 0) begin
         $display("%0t: unexpected message: expected none, actual kind %0d seq %0h",
                  $time, rsp_message_kind, rsp_sequence_number);
         error_count++;
         return;
      end
      want = book_msgs_due[0];
      book_msgs_due.delete(0);
      compare_field("message_kind", 64'(want.message_kind), 64'(rsp_message_kind));
      compare_field("sequence_number", want.sequence_number, rsp_sequence_number);
      compare_field("out_time", want.out_time, rsp_out_time);
      compare_field("out_symbol", 64'(want.out_symbol), 64'(rsp_out_symbol));
      compare_field("out_order", want.out_order, rsp_out_order);
      compare_field("out_price", 64'(want.out_price), 64'(rsp_out_price));
      compare_field("out_quantity", 64'(want.out_quantity), 64'(rsp_out_quantity));
      compare_field("is_sell", 64'(want.is_sell), 64'(rsp_is_sell));
      compare_field("last_of_event", 64'(want.last_of_event), 64'(rsp_last_of_event));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_book_message();
   end

   // Watchdog: cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: watchdog expired with %0d messages outstanding",
                     $time, book_msgs_due.size());
            $display("order_event_normalizer test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Accept and drop rules of every command, field extremes
   task automatic test_event_rules();
      send_event(build_event(oen_pkg::CMD_ADD, '0, 32'd1, '0, '0, '0, 32'd1, BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, ALL_ONES, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES,
                             PRICE_MAX, QTY_MAX, oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, 64'd10, 32'd2, 64'd3, 64'd4, PRICE_MIN,
                             32'd5, BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, 64'd11, 32'd2, 64'd3, 64'd4, 64'sd7, '0,
                             BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, 64'd12, 32'd2, 64'd3, 64'd4, 64'sd7, 32'd5,
                             oen_pkg::ABSENT_CHAR));
      // modify may carry zero quantity
      send_event(build_event(oen_pkg::CMD_MODIFY, 64'd13, 32'd9, 64'd20, '0, PRICE_MAX, '0,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_MODIFY, 64'd14, 32'd9, 64'd20, '0, -64'sd1, 32'd5,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_MODIFY, 64'd15, 32'd9, 64'd20, '0, 64'sd5, 32'd5,
                             oen_pkg::ABSENT_CHAR));
      // delete with a known symbol always goes out; absent side reads as buy
      send_event(build_event(oen_pkg::CMD_DELETE, 64'd16, 32'd9, ALL_ONES, '0, PRICE_MIN,
                             QTY_MAX, oen_pkg::ABSENT_CHAR));
      send_event(build_event(oen_pkg::CMD_DELETE, 64'd17, 32'd9, 64'd21, '0, PRICE_MAX,
                             32'd3, oen_pkg::SELL_CHAR));
      // execution clamps a negative price
      send_event(build_event(oen_pkg::CMD_EXECUTE, 64'd18, 32'd7, 64'd22, '0, PRICE_MIN,
                             32'd8, oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_EXECUTE, 64'd19, 32'd7, 64'd22, '0, 64'sd8, '0,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_EXECUTE, 64'd20, 32'd7, 64'd22, '0, 64'sd8,
                             QTY_MAX, oen_pkg::ABSENT_CHAR));
      // replace: valid, then each check failing in turn
      send_event(build_event(oen_pkg::CMD_REPLACE, 64'd21, 32'd5, 64'd30, 64'd31, 64'sd99,
                             32'd4, oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_REPLACE, 64'd22, 32'd5, 64'd30, '0, 64'sd99,
                             32'd4, oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_REPLACE, 64'd23, 32'd5, 64'd30, 64'd31, -64'sd5,
                             32'd4, BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_REPLACE, 64'd24, 32'd5, 64'd30, 64'd31, 64'sd99,
                             32'd4, oen_pkg::ABSENT_CHAR));
      send_event(build_event(oen_pkg::CMD_REPLACE, 64'd25, 32'd5, 64'd30, 64'd31, 64'sd99,
                             '0, BUY_CHAR));
      wait_for_results();
      // unknown symbol drops even a delete
      send_event(build_event(oen_pkg::CMD_ADD, 64'd26, '0, 64'd1, 64'd2, 64'sd1, 32'd1,
                             BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_DELETE, 64'd27, '0, 64'd1, 64'd2, 64'sd1, 32'd1,
                             BUY_CHAR));
      // ignored kinds leave the counter alone
      send_event(build_event(CMD_TRADE_REPORT, 64'd28, 32'd3, 64'd1, 64'd2, 64'sd1, 32'd1,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(CMD_UNKNOWN, 64'd29, 32'd3, 64'd1, 64'd2, 64'sd1, 32'd1,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(CMD_MAX, 64'd30, 32'd3, 64'd1, 64'd2, 64'sd1, 32'd1,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, 64'd31, 32'd3, 64'd1, 64'd2, 64'sd1, 32'd1,
                             8'hFF));
   endtask

   // Counter reload and wrap at the register extremes
   task automatic test_sequence_config();
      write_first_sequence(64'hFFFF_FFFF_FFFF_FFFE);
      send_event(build_event(oen_pkg::CMD_REPLACE, rand64(), 32'd4, 64'd40, 64'd41, 64'sd10,
                             32'd2, BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_ADD, rand64(), 32'd4, 64'd41, '0, 64'sd11, 32'd2,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(CMD_STATUS, rand64(), 32'd4, 64'd41, '0, 64'sd11, 32'd2,
                             oen_pkg::SELL_CHAR));
      send_event(build_event(oen_pkg::CMD_DELETE, rand64(), 32'd4, 64'd41, '0, 64'sd11,
                             32'd2, oen_pkg::SELL_CHAR));
      write_first_sequence(ALL_ONES);
      send_event(build_event(oen_pkg::CMD_DELETE, rand64(), 32'd6, 64'd50, '0, '0, '0,
                             BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_EXECUTE, rand64(), 32'd6, 64'd50, '0, 64'sd3,
                             32'd1, BUY_CHAR));
      write_first_sequence('0);
      send_event(build_event(oen_pkg::CMD_ADD, rand64(), 32'd6, 64'd51, '0, 64'sd3, 32'd1,
                             BUY_CHAR));
      send_event(build_event(CMD_SUMMARY, rand64(), 32'd6, 64'd51, '0, 64'sd3, 32'd1,
                             BUY_CHAR));
      send_event(build_event(CMD_IMBALANCE, rand64(), 32'd6, 64'd51, '0, 64'sd3, 32'd1,
                             BUY_CHAR));
      send_event(build_event(oen_pkg::CMD_MODIFY, rand64(), 32'd6, 64'd51, '0, 64'sd4,
                             32'd1, oen_pkg::SELL_CHAR));
   endtask

   // Random traffic in phases; counter reloaded between phases
   task automatic test_random_traffic();
      logic [63:0] start_seq;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: start_seq = 64'hFFFF_FFFF_FFFF_FFF0;
            2: start_seq = '0;
            default: start_seq = rand64();
         endcase
         write_first_sequence(start_seq);
         // one phase runs with no idling on either side
         traffic_stall = (phase != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_event(random_event());
            if ($urandom_range(0, 149) == 0) wait_for_results();
         end
      end
      traffic_stall = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_event_rules();
      test_sequence_config();
      test_random_traffic();
      wait_for_idle();
      if (error_count == 0) begin
         $display("order_event_normalizer test passed");
      end else begin
         $display("order_event_normalizer test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
